// ===== design/onewire_scratchpad_receiver_defines.svh =====
// assertion macros shared by the scratchpad receiver modules
`ifndef ONEWIRE_SCRATCHPAD_RECEIVER_DEFINES_SVH
`define ONEWIRE_SCRATCHPAD_RECEIVER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define OWSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define OWSR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/owsr_pkg.sv =====
// types, constants and crc function of the scratchpad receiver
package owsr_pkg;

    localparam int BUF_DEPTH = 16;
    localparam int BUF_IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 5;
    localparam int LEN_W    = 5;
    localparam int CRC_W    = 16;

    localparam logic [CMD_W-1:0] CMD_BYTE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BUSERR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    localparam logic [BYTE_W-1:0] OPEN_CMD = 8'h0F;
    localparam logic [BYTE_W-1:0] MAX_LEN  = 8'd16;

    localparam logic [STATUS_W-1:0] ST_VALID   = 5'h01;
    localparam logic [STATUS_W-1:0] ST_LONG    = 5'h02;
    localparam logic [STATUS_W-1:0] ST_BUSERR  = 5'h04;
    localparam logic [STATUS_W-1:0] ST_CRCBAD  = 5'h08;
    localparam logic [STATUS_W-1:0] ST_OVERRUN = 5'h10;

    localparam logic [CRC_W-1:0] CRC_XOR = 16'hC001;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [BYTE_W-1:0]  rx_byte;
        logic [INDEX_W-1:0] buf_index;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                frame_done;
        logic [BYTE_W-1:0]   row_addr;
        logic [LEN_W-1:0]    frame_len;
        logic [BYTE_W-1:0]   read_data;
    } result_t;

    // bytewise crc-16, reflected 0xa001
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        logic [CRC_W-1:0]  ce;
        logic [CRC_W-1:0]  r;
        c  = b ^ crc[BYTE_W-1:0];
        ce = {{(CRC_W-BYTE_W){1'b0}}, c};
        r  = crc >> BYTE_W;
        if (^c)
        begin
            r = r ^ CRC_XOR;
        end
        r = r ^ (ce << 6) ^ (ce << 7);
        return r;
    endfunction

endpackage

// ===== design/owsr_frame.sv =====
// frame state, running crc, data buffer and status of the receiver
`include "onewire_scratchpad_receiver_defines.svh"

module owsr_frame
    import owsr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    output result_t result
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_ADDR  = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_CRCLO = 3'd4;
    localparam logic [2:0] PH_CRCHI = 3'd5;

    logic [2:0]          phase_reg, phase_next;
    logic [BYTE_W-1:0]   frame_addr_reg, frame_addr_next;
    logic [LEN_W-1:0]    frame_length_reg, frame_length_next;
    logic [LEN_W-1:0]    byte_count_reg, byte_count_next;
    logic [CRC_W-1:0]    crc_accum_reg, crc_accum_next;
    logic [BYTE_W-1:0]   crc_low_byte_reg, crc_low_byte_next;
    logic [STATUS_W-1:0] status_bits_reg, status_bits_next;
    logic [BYTE_W-1:0]   frame_buffer_reg [BUF_DEPTH];

    logic                 done;
    logic [BYTE_W-1:0]    rd;
    logic                 wr_en;
    logic [BUF_IDX_W-1:0] wr_idx;
    logic [BUF_IDX_W-1:0] rd_idx;

    assign wr_idx = BUF_IDX_W'(byte_count_reg);
    assign rd_idx = BUF_IDX_W'(item.buf_index);

    always_comb
    begin
        phase_next        = phase_reg;
        frame_addr_next   = frame_addr_reg;
        frame_length_next = frame_length_reg;
        byte_count_next   = byte_count_reg;
        crc_accum_next    = crc_accum_reg;
        crc_low_byte_next = crc_low_byte_reg;
        status_bits_next  = status_bits_reg;
        done              = 1'b0;
        rd                = '0;
        wr_en             = 1'b0;
        unique case (item.cmd)
            CMD_BYTE:
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (item.rx_byte == OPEN_CMD)
                        begin
                            if ((status_bits_reg & ST_VALID) != '0)
                            begin
                                status_bits_next = status_bits_reg | ST_OVERRUN;
                            end
                            crc_accum_next  = '0;
                            byte_count_next = '0;
                            phase_next      = PH_ADDR;
                        end
                    end
                    PH_ADDR:
                    begin
                        frame_addr_next = item.rx_byte;
                        crc_accum_next  = crc_byte(crc_accum_reg, item.rx_byte);
                        phase_next      = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        if (item.rx_byte > MAX_LEN)
                        begin
                            status_bits_next = status_bits_reg | ST_LONG;
                            phase_next       = PH_IDLE;
                        end
                        else
                        begin
                            frame_length_next = item.rx_byte[LEN_W-1:0];
                            crc_accum_next    = crc_byte(crc_accum_reg, item.rx_byte);
                            byte_count_next   = '0;
                            phase_next        = (item.rx_byte == '0) ? PH_CRCLO : PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        wr_en           = (32'(byte_count_reg) < BUF_DEPTH);
                        crc_accum_next  = crc_byte(crc_accum_reg, item.rx_byte);
                        byte_count_next = byte_count_reg + 1'b1;
                        if (byte_count_next >= frame_length_reg)
                        begin
                            phase_next = PH_CRCLO;
                        end
                    end
                    PH_CRCLO:
                    begin
                        crc_low_byte_next = item.rx_byte;
                        phase_next        = PH_CRCHI;
                    end
                    PH_CRCHI:
                    begin
                        if ({item.rx_byte, crc_low_byte_reg} != crc_accum_reg)
                        begin
                            status_bits_next = status_bits_next | ST_CRCBAD;
                        end
                        status_bits_next = status_bits_next | ST_VALID;
                        done             = 1'b1;
                        phase_next       = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            CMD_BUSERR:
            begin
                if (phase_reg == PH_DATA)
                begin
                    status_bits_next = status_bits_reg | ST_BUSERR;
                    phase_next       = PH_IDLE;
                end
            end
            CMD_CLEAR:
            begin
                status_bits_next = '0;
            end
            CMD_READ:
            begin
                if (32'(item.buf_index) < BUF_DEPTH)
                begin
                    rd = frame_buffer_reg[rd_idx];
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    assign result.status     = status_bits_next;
    assign result.frame_done = done;
    assign result.row_addr   = frame_addr_next;
    assign result.frame_len  = frame_length_next;
    assign result.read_data  = rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            frame_addr_reg   <= '0;
            frame_length_reg <= '0;
            byte_count_reg   <= '0;
            crc_accum_reg    <= '0;
            crc_low_byte_reg <= '0;
            status_bits_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg        <= phase_next;
            frame_addr_reg   <= frame_addr_next;
            frame_length_reg <= frame_length_next;
            byte_count_reg   <= byte_count_next;
            crc_accum_reg    <= crc_accum_next;
            crc_low_byte_reg <= crc_low_byte_next;
            status_bits_reg  <= status_bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && wr_en)
        begin
            frame_buffer_reg[wr_idx] <= item.rx_byte;
        end
    end

    `OWSR_ASSERT_NOW(a_len_bound, 1'b1, frame_length_reg <= LEN_W'(MAX_LEN),
        "frame length above limit")
    `OWSR_ASSERT_NOW(a_data_count, phase_reg == PH_DATA, byte_count_reg < frame_length_reg,
        "data phase with count at or past length")
    `OWSR_ASSERT_NXT(a_done_idle, fire && done, phase_reg == PH_IDLE && status_bits_reg[0],
        "completed frame did not return to idle with valid set")

endmodule

// ===== design/onewire_scratchpad_receiver.sv =====
// top level: input register, frame logic and result register
// an accepted item is registered in the input register, then its result in the result register
// throughput: one item per cycle when no result stall, limited by the single frame state update
// both stages advance together when the result register is free or being taken
// reset: async active low clears phase, crc, counters, status and valid flags
// buffer contents are not reset; the user must read back only after being written, unenforced here
`include "onewire_scratchpad_receiver_defines.svh"

module onewire_scratchpad_receiver
    import owsr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [BYTE_W-1:0]   rx_byte,
    input  logic [INDEX_W-1:0]  buf_index,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [STATUS_W-1:0] status,
    output logic                frame_done,
    output logic [BYTE_W-1:0]   row_addr,
    output logic [LEN_W-1:0]    frame_len,
    output logic [BYTE_W-1:0]   read_data
);

    logic    s1_valid_reg;
    item_t   s1_item_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t result_next;
    logic    out_free;
    logic    fire;
    logic    take;

    assign out_free   = !out_valid_reg || !result_stall;
    assign fire       = s1_valid_reg && out_free;
    assign item_stall = s1_valid_reg && !out_free;
    assign take       = item_valid && !item_stall;

    owsr_frame u_frame
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (s1_item_reg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_item_reg.cmd       <= cmd;
            s1_item_reg.rx_byte   <= rx_byte;
            s1_item_reg.buf_index <= buf_index;
        end
        if (fire)
        begin
            out_reg <= result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = out_reg.status;
    assign frame_done   = out_reg.frame_done;
    assign row_addr     = out_reg.row_addr;
    assign frame_len    = out_reg.frame_len;
    assign read_data    = out_reg.read_data;

    `OWSR_ASSERT_NOW(a_done_valid, out_valid_reg && out_reg.frame_done, out_reg.status[0],
        "frame done without valid status")
    `OWSR_ASSERT_NXT(a_fire_result, fire, out_valid_reg,
        "processed item did not reach result register")
    `OWSR_ASSERT_NXT(a_result_hold, out_valid_reg && result_stall,
        out_valid_reg && $stable(out_reg), "stalled result changed")

endmodule

// ===== tb/onewire_scratchpad_receiver_tb.sv =====
// testbench for the 1-wire scratchpad receiver: directed rows, random frames, self-checking
`timescale 1ns / 1ps

module onewire_scratchpad_receiver_tb;
    import owsr_pkg::*;

    localparam int               ITEMS_TOTAL    = 1300;
    localparam int               WATCHDOG_LIMIT = 2000;
    localparam int               SETTLE_CYCLES  = 10;
    localparam int               MAX_REPORTS    = 10;
    localparam logic [CRC_W-1:0] CRC_POLY       = 16'hA001;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ADDR,
        PH_LEN,
        PH_DATA,
        PH_CRCLO,
        PH_CRCHI
    } frame_phase_e;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [BYTE_W-1:0]   rx;
        logic [INDEX_W-1:0]  idx;
        logic                typed;
        logic [STATUS_W-1:0] st;
        logic                done;
        logic [BYTE_W-1:0]   addr;
        logic [LEN_W-1:0]    len;
        logic [BYTE_W-1:0]   rd;
    } dir_row_t;

    localparam int N_DIR = 27;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_stall;
    logic [CMD_W-1:0]    cmd          = CMD_BYTE;
    logic [BYTE_W-1:0]   rx_byte      = '0;
    logic [INDEX_W-1:0]  buf_index    = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic                frame_done;
    logic [BYTE_W-1:0]   row_addr;
    logic [LEN_W-1:0]    frame_len;
    logic [BYTE_W-1:0]   read_data;

    // shadow of the frame receiver
    frame_phase_e        sp_phase  = PH_IDLE;
    logic [BYTE_W-1:0]   sp_addr   = '0;
    logic [LEN_W-1:0]    sp_len    = '0;
    logic [LEN_W-1:0]    sp_count  = '0;
    logic [CRC_W-1:0]    sp_crc    = '0;
    logic [BYTE_W-1:0]   sp_crc_lo = '0;
    logic [STATUS_W-1:0] sp_status = '0;
    logic [BYTE_W-1:0]   sp_buf     [BUF_DEPTH];
    bit                  sp_written [BUF_DEPTH];

    result_t pending_results[$];
    int      mismatches  = 0;
    int      items_sent  = 0;
    int      burst_left  = 0;
    int      idle_cycles = 0;
    bit      use_typed   = 1'b0;
    result_t typed_want  = '0;

    int          stall_left = 0;
    int          stall_mode = 0;
    logic [7:0]  stall_pat  = '0;

    dir_row_t dir_rows [N_DIR] = '{
        '{CMD_BYTE,   8'h00,    4'h0, 1'b1, 5'h00,                        1'b0, 8'h00, 5'd0, 8'h00},
        '{CMD_BUSERR, 8'h00,    4'h0, 1'b1, 5'h00,                        1'b0, 8'h00, 5'd0, 8'h00},
        '{CMD_CLEAR,  8'h00,    4'h0, 1'b1, 5'h00,                        1'b0, 8'h00, 5'd0, 8'h00},
        '{CMD_BYTE,   OPEN_CMD, 4'h0, 1'b1, 5'h00,                        1'b0, 8'h00, 5'd0, 8'h00},
        '{CMD_BYTE,   8'hFF,    4'h0, 1'b1, 5'h00,                        1'b0, 8'hFF, 5'd0, 8'h00},
        '{CMD_BYTE,   8'h11,    4'h0, 1'b1, ST_LONG,                      1'b0, 8'hFF, 5'd0, 8'h00},
        '{CMD_BYTE,   OPEN_CMD, 4'h0, 1'b1, ST_LONG,                      1'b0, 8'hFF, 5'd0, 8'h00},
        '{CMD_BYTE,   8'h00,    4'h0, 1'b1, ST_LONG,                      1'b0, 8'h00, 5'd0, 8'h00},
        '{CMD_BUSERR, 8'h00,    4'h0, 1'b1, ST_LONG,                      1'b0, 8'h00, 5'd0, 8'h00},
        '{CMD_BYTE,   8'h00,    4'h0, 1'b1, ST_LONG,                      1'b0, 8'h00, 5'd0, 8'h00},
        '{CMD_BYTE,   8'h00,    4'h0, 1'b1, ST_LONG,                      1'b0, 8'h00, 5'd0, 8'h00},
        '{CMD_BYTE,   8'h00,    4'h0, 1'b1, ST_LONG | ST_VALID,           1'b1, 8'h00, 5'd0, 8'h00},
        '{CMD_BYTE,   OPEN_CMD, 4'h0, 1'b1, ST_LONG | ST_VALID | ST_OVERRUN,
                                                                          1'b0, 8'h00, 5'd0, 8'h00},
        '{CMD_BYTE,   8'h5A,    4'h0, 1'b0, 5'h00,                        1'b0, 8'h00, 5'd0, 8'h00},
        '{CMD_BYTE,   8'h02,    4'h0, 1'b0, 5'h00,                        1'b0, 8'h00, 5'd0, 8'h00},
        '{CMD_BYTE,   8'h80,    4'h0, 1'b0, 5'h00,                        1'b0, 8'h00, 5'd0, 8'h00},
        '{CMD_BUSERR, 8'h00,    4'h0, 1'b1, ST_LONG | ST_VALID | ST_OVERRUN | ST_BUSERR,
                                                                          1'b0, 8'h5A, 5'd2, 8'h00},
        '{CMD_READ,   8'h00,    4'h0, 1'b0, 5'h00,                        1'b0, 8'h00, 5'd0, 8'h00},
        '{CMD_CLEAR,  8'h00,    4'h0, 1'b1, 5'h00,                        1'b0, 8'h5A, 5'd2, 8'h00},
        '{CMD_BYTE,   OPEN_CMD, 4'h0, 1'b0, 5'h00,                        1'b0, 8'h00, 5'd0, 8'h00},
        '{CMD_BYTE,   8'h01,    4'h0, 1'b0, 5'h00,                        1'b0, 8'h00, 5'd0, 8'h00},
        '{CMD_BYTE,   8'h01,    4'h0, 1'b0, 5'h00,                        1'b0, 8'h00, 5'd0, 8'h00},
        '{CMD_BYTE,   8'h7F,    4'h0, 1'b0, 5'h00,                        1'b0, 8'h00, 5'd0, 8'h00},
        '{CMD_BYTE,   8'h12,    4'h0, 1'b0, 5'h00,                        1'b0, 8'h00, 5'd0, 8'h00},
        '{CMD_BUSERR, 8'h00,    4'h0, 1'b0, 5'h00,                        1'b0, 8'h00, 5'd0, 8'h00},
        '{CMD_BYTE,   8'h34,    4'h0, 1'b0, 5'h00,                        1'b0, 8'h00, 5'd0, 8'h00},
        '{CMD_READ,   8'h00,    4'h0, 1'b0, 5'h00,                        1'b0, 8'h00, 5'd0, 8'h00}
    };

    onewire_scratchpad_receiver u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (cmd),
        .rx_byte      (rx_byte),
        .buf_index    (buf_index),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .frame_done   (frame_done),
        .row_addr     (row_addr),
        .frame_len    (frame_len),
        .read_data    (read_data)
    );

    always #5 clk = ~clk;

    // crc-16 arc, shifted out lsb first
    function automatic logic [CRC_W-1:0] crc16_update(input logic [CRC_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        r = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic result_t predict_scratchpad(input item_t it);
        result_t res;
        res = '0;
        case (it.cmd)
            CMD_BYTE:
            begin
                case (sp_phase)
                    PH_IDLE:
                    begin
                        if (it.rx_byte == OPEN_CMD)
                        begin
                            if ((sp_status & ST_VALID) != '0)
                            begin
                                sp_status = sp_status | ST_OVERRUN;
                            end
                            sp_crc   = '0;
                            sp_count = '0;
                            sp_phase = PH_ADDR;
                        end
                    end
                    PH_ADDR:
                    begin
                        sp_addr  = it.rx_byte;
                        sp_crc   = crc16_update(sp_crc, it.rx_byte);
                        sp_phase = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        if (it.rx_byte > MAX_LEN)
                        begin
                            sp_status = sp_status | ST_LONG;
                            sp_phase  = PH_IDLE;
                        end
                        else
                        begin
                            sp_len   = it.rx_byte[LEN_W-1:0];
                            sp_crc   = crc16_update(sp_crc, it.rx_byte);
                            sp_count = '0;
                            sp_phase = (it.rx_byte == '0) ? PH_CRCLO : PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        if (32'(sp_count) < BUF_DEPTH)
                        begin
                            sp_buf[BUF_IDX_W'(sp_count)]     = it.rx_byte;
                            sp_written[BUF_IDX_W'(sp_count)] = 1'b1;
                        end
                        sp_crc   = crc16_update(sp_crc, it.rx_byte);
                        sp_count = sp_count + 1'b1;
                        if (sp_count >= sp_len)
                        begin
                            sp_phase = PH_CRCLO;
                        end
                    end
                    PH_CRCLO:
                    begin
                        sp_crc_lo = it.rx_byte;
                        sp_phase  = PH_CRCHI;
                    end
                    PH_CRCHI:
                    begin
                        if ({it.rx_byte, sp_crc_lo} != sp_crc)
                        begin
                            sp_status = sp_status | ST_CRCBAD;
                        end
                        sp_status      = sp_status | ST_VALID;
                        res.frame_done = 1'b1;
                        sp_phase       = PH_IDLE;
                    end
                    default:
                    begin
                        sp_phase = PH_IDLE;
                    end
                endcase
            end
            CMD_BUSERR:
            begin
                if (sp_phase == PH_DATA)
                begin
                    sp_status = sp_status | ST_BUSERR;
                    sp_phase  = PH_IDLE;
                end
            end
            CMD_CLEAR:
            begin
                sp_status = '0;
            end
            default:
            begin
                if (32'(it.buf_index) < BUF_DEPTH)
                begin
                    res.read_data = sp_buf[BUF_IDX_W'(it.buf_index)];
                end
            end
        endcase
        res.status    = sp_status;
        res.row_addr  = sp_addr;
        res.frame_len = sp_len;
        return res;
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
            end
        end
    endtask

    // result checking, prediction on accept, watchdog
    always @(posedge clk)
    begin
        result_t want;
        result_t predicted;
        item_t   taken;
        bit      moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (result_valid && !result_stall)
            begin
                moved = 1'b1;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("unexpected result: status 0x%0h frame_done %0b", status,
                                 frame_done);
                    end
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("frame_done", 32'(want.frame_done), 32'(frame_done));
                    check_field("row_addr", 32'(want.row_addr), 32'(row_addr));
                    check_field("frame_len", 32'(want.frame_len), 32'(frame_len));
                    check_field("read_data", 32'(want.read_data), 32'(read_data));
                end
            end
            if (item_valid && !item_stall)
            begin
                moved           = 1'b1;
                taken.cmd       = cmd;
                taken.rx_byte   = rx_byte;
                taken.buf_index = buf_index;
                predicted       = predict_scratchpad(taken);
                pending_results.push_back(use_typed ? typed_want : predicted);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
            stall_pat  = 8'($urandom) & 8'hFE;
        end
        stall_left--;
        stall_pat = {stall_pat[0], stall_pat[7:1]};
        case (stall_mode)
            0:       result_stall = 1'b0;
            1:       result_stall = ($urandom_range(0, 3) == 0);
            2:       result_stall = stall_pat[0];
            default: result_stall = ($urandom_range(0, 99) < 70);
        endcase
    end

    task automatic send_item(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b,
                             input logic [INDEX_W-1:0] i, input bit counted);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        cmd        = c;
        rx_byte    = b;
        buf_index  = i;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
        if (counted)
        begin
            items_sent++;
        end
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        send_item(CMD_BYTE, b, INDEX_W'($urandom), 1'b1);
    endtask

    task automatic send_read();
        int start;
        int k;
        start = $urandom_range(0, BUF_DEPTH - 1);
        for (k = 0; k < BUF_DEPTH; k++)
        begin
            if (sp_written[BUF_IDX_W'((start + k) % BUF_DEPTH)])
            begin
                break;
            end
        end
        if (k < BUF_DEPTH)
        begin
            send_item(CMD_READ, BYTE_W'($urandom), INDEX_W'((start + k) % BUF_DEPTH), 1'b1);
        end
        else
        begin
            send_item(CMD_CLEAR, BYTE_W'($urandom), INDEX_W'($urandom), 1'b1);
        end
    endtask

    task automatic drain_results();
        item_valid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // mostly well-formed frames; some too long, or with bad crc, bus error, truncation or host traffic
    task automatic send_frame();
        logic [BYTE_W-1:0] bytes[$];
        logic [BYTE_W-1:0] addr_b;
        logic [BYTE_W-1:0] len_b;
        logic [BYTE_W-1:0] data_b;
        logic [CRC_W-1:0]  crc;
        int                fault;
        int                stop_at;
        int                err_at;
        int                pick;
        fault   = $urandom_range(0, 99);
        addr_b  = BYTE_W'($urandom);
        len_b   = (fault < 8) ? BYTE_W'($urandom_range(32'(MAX_LEN) + 1, 255))
                              : BYTE_W'($urandom_range(0, 32'(MAX_LEN)));
        crc     = crc16_update(crc16_update('0, addr_b), len_b);
        bytes   = '{OPEN_CMD, addr_b, len_b};
        err_at  = -1;
        if (len_b <= MAX_LEN)
        begin
            for (int k = 0; k < 32'(len_b); k++)
            begin
                data_b = BYTE_W'($urandom);
                crc    = crc16_update(crc, data_b);
                bytes.push_back(data_b);
            end
            if (fault >= 8 && fault < 18)
            begin
                crc = crc ^ CRC_W'($urandom_range(1, 16'hFFFF));
            end
            bytes.push_back(crc[7:0]);
            bytes.push_back(crc[15:8]);
            if (fault >= 18 && fault < 26 && len_b != 0)
            begin
                err_at = 3 + int'($urandom_range(0, 32'(len_b) - 1));
            end
        end
        stop_at = (fault >= 26 && fault < 30) ? $urandom_range(1, bytes.size() - 1)
                                              : bytes.size();
        for (int j = 0; j < stop_at; j++)
        begin
            if (j == err_at)
            begin
                send_item(CMD_BUSERR, BYTE_W'($urandom), INDEX_W'($urandom), 1'b1);
                break;
            end
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                send_read();
            end
            else if (pick < 6)
            begin
                send_item(CMD_CLEAR, BYTE_W'($urandom), INDEX_W'($urandom), 1'b1);
            end
            else if (pick < 8 && (j < 3 || j >= 3 + 32'(len_b)))
            begin
                send_item(CMD_BUSERR, BYTE_W'($urandom), INDEX_W'($urandom), 1'b1);
            end
            send_byte(bytes[j]);
        end
    endtask

    initial
    begin
        int               r;
        logic [BYTE_W-1:0] noise;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int n = 0; n < N_DIR; n++)
        begin
            use_typed            = dir_rows[n].typed;
            typed_want.status     = dir_rows[n].st;
            typed_want.frame_done = dir_rows[n].done;
            typed_want.row_addr   = dir_rows[n].addr;
            typed_want.frame_len  = dir_rows[n].len;
            typed_want.read_data  = dir_rows[n].rd;
            send_item(dir_rows[n].cmd, dir_rows[n].rx, dir_rows[n].idx, 1'b1);
        end
        use_typed = 1'b0;
        drain_results();

        while (items_sent < ITEMS_TOTAL)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                send_frame();
            end
            else if (r < 80)
            begin
                send_read();
            end
            else if (r < 85)
            begin
                send_item(CMD_CLEAR, BYTE_W'($urandom), INDEX_W'($urandom), 1'b1);
            end
            else if (r < 92)
            begin
                noise = BYTE_W'($urandom);
                if (noise == OPEN_CMD)
                begin
                    noise = noise ^ 8'h01;
                end
                send_item(CMD_BYTE, noise, INDEX_W'($urandom), sp_phase != PH_IDLE);
            end
            else if (r < 97)
            begin
                send_item(CMD_BUSERR, BYTE_W'($urandom), INDEX_W'($urandom),
                          sp_phase == PH_DATA);
            end
            else
            begin
                drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
